### sv/assert_macros.svh
// Assertion macros used by the top level of the yaw extraction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// An antecedent that, in the same cycle, implies a consequent outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### sv/qye_pkg.sv
// Package of widths, constants and types for the quaternion yaw extraction block.
package qye_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int ITERATIONS      = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_STAGES   = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

  // Product widths; wide components are cut back to keep 30 fraction bits.
  localparam int PROD_W      = 2 * COMPONENT_WIDTH;
  localparam int PROD_SHIFT  = (COMPONENT_WIDTH > 16) ? (2 * COMPONENT_WIDTH - 32) : 0;
  localparam int SP_W        = PROD_W - PROD_SHIFT;
  localparam int ONE_EXP     = SP_W - 2;
  localparam int NUM_W       = SP_W + 2;
  localparam int GUARD_SHIFT = 38 - ONE_EXP;
  localparam int VEC_W       = NUM_W + GUARD_SHIFT + 4;

  localparam int BAM_W      = 32;
  localparam int ANG_W      = BAM_W + 1;
  localparam int OUT_W      = 16;
  localparam int RAD_PROD_W = 64;
  localparam int DEG_PROD_W = ANG_W + 8;
  localparam int RAD_SHIFT  = 47;
  localparam int DEG_SHIFT  = 22;

  localparam logic signed [NUM_W-1:0] DEN_ONE =
    {{(NUM_W - ONE_EXP - 1){1'b0}}, 1'b1, {ONE_EXP{1'b0}}};
  localparam logic [BAM_W-1:0] BAM_PI = 32'h8000_0000;
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
  localparam logic signed [7:0] DEG_SCALE = 8'sd45;
  localparam logic signed [RAD_PROD_W-1:0] RAD_ROUND = 64'sd1 <<< 46;
  localparam logic signed [DEG_PROD_W-1:0] DEG_ROUND = DEG_PROD_W'(64'sd1 <<< 21);

  // Largest magnitudes of the two results, pi in Q2.13 and 180 in Q8.7.
  localparam logic signed [OUT_W-1:0] YAW_RAD_MAX = 16'sd25736;
  localparam logic signed [OUT_W-1:0] YAW_DEG_MAX = 16'sd23040;

  // Arctangent of 2^-i in binary angle units, 2^32 per turn.
  localparam logic [BAM_W-1:0] ATAN_BAM [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] w;
    logic signed [COMPONENT_WIDTH-1:0] z;
    logic signed [COMPONENT_WIDTH-1:0] y;
    logic signed [COMPONENT_WIDTH-1:0] x;
  } quat_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] wz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
  } prod_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [BAM_W-1:0]        z;
    logic                    zero;
  } vec_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] deg;
    logic signed [OUT_W-1:0] rad;
  } yaw_t;

endpackage

### sv/qye_front.sv
// Front end: quaternion products, then numerator, denominator and quadrant pre-rotation.
module qye_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qye_pkg::quat_t in_quat,
  output logic          out_valid,
  input  logic          out_ready,
  output qye_pkg::vec_t out_vec
);

  qye_pkg::prod_t prod_r;
  logic           prod_vld_r;
  logic           prod_rdy;
  qye_pkg::vec_t  vec_r;
  qye_pkg::vec_t  vec_nxt;
  logic           vec_vld_r;
  logic           vec_rdy;

  logic signed [qye_pkg::PROD_W-1:0] wz_full, xy_full, yy_full, zz_full;
  logic signed [qye_pkg::NUM_W-1:0]  num, den, num_sum, den_sum;
  logic signed [qye_pkg::VEC_W-1:0]  x_ext, y_ext;

  assign vec_rdy  = !vec_vld_r || out_ready;
  assign prod_rdy = !prod_vld_r || vec_rdy;
  assign in_ready = prod_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      vec_vld_r  <= 1'b0;
    end else begin
      if (prod_rdy) prod_vld_r <= in_valid;
      if (vec_rdy) vec_vld_r <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && prod_rdy) begin
      prod_r.wz <= qye_pkg::PROD_W'(in_quat.w) * qye_pkg::PROD_W'(in_quat.z);
      prod_r.xy <= qye_pkg::PROD_W'(in_quat.x) * qye_pkg::PROD_W'(in_quat.y);
      prod_r.yy <= qye_pkg::PROD_W'(in_quat.y) * qye_pkg::PROD_W'(in_quat.y);
      prod_r.zz <= qye_pkg::PROD_W'(in_quat.z) * qye_pkg::PROD_W'(in_quat.z);
    end
    if (prod_vld_r && vec_rdy) begin
      vec_r <= vec_nxt;
    end
  end

  always_comb begin
    wz_full = prod_r.wz >>> qye_pkg::PROD_SHIFT;
    xy_full = prod_r.xy >>> qye_pkg::PROD_SHIFT;
    yy_full = prod_r.yy >>> qye_pkg::PROD_SHIFT;
    zz_full = prod_r.zz >>> qye_pkg::PROD_SHIFT;
    num_sum = {{2{wz_full[qye_pkg::SP_W-1]}}, wz_full[qye_pkg::SP_W-1:0]}
            + {{2{xy_full[qye_pkg::SP_W-1]}}, xy_full[qye_pkg::SP_W-1:0]};
    den_sum = {{2{yy_full[qye_pkg::SP_W-1]}}, yy_full[qye_pkg::SP_W-1:0]}
            + {{2{zz_full[qye_pkg::SP_W-1]}}, zz_full[qye_pkg::SP_W-1:0]};
    num = num_sum <<< 1;
    den = qye_pkg::DEN_ONE - (den_sum <<< 1);
    x_ext = {{(qye_pkg::VEC_W - qye_pkg::NUM_W){den[qye_pkg::NUM_W-1]}}, den};
    y_ext = {{(qye_pkg::VEC_W - qye_pkg::NUM_W){num[qye_pkg::NUM_W-1]}}, num};
    x_ext = x_ext <<< qye_pkg::GUARD_SHIFT;
    y_ext = y_ext <<< qye_pkg::GUARD_SHIFT;
    vec_nxt.zero = (num == '0) && (den == '0);
    // A vector in the left half-plane is turned by pi; both signs of pi wrap alike.
    if (den[qye_pkg::NUM_W-1]) begin
      vec_nxt.x = -x_ext;
      vec_nxt.y = -y_ext;
      vec_nxt.z = qye_pkg::BAM_PI;
    end else begin
      vec_nxt.x = x_ext;
      vec_nxt.y = y_ext;
      vec_nxt.z = '0;
    end
  end

  assign out_valid = vec_vld_r;
  assign out_vec   = vec_r;

endmodule

### sv/qye_cordic.sv
// Unrolled vectoring CORDIC, one registered stage per iteration.
module qye_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qye_pkg::vec_t in_vec,
  output logic          out_valid,
  input  logic          out_ready,
  output qye_pkg::vec_t out_vec
);

  localparam int STAGES = qye_pkg::CORDIC_STAGES;

  qye_pkg::vec_t st_r    [STAGES];
  qye_pkg::vec_t src_w   [STAGES];
  qye_pkg::vec_t st_nxt  [STAGES];
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] src_vld;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign src_w[i]   = in_vec;
      assign src_vld[i] = in_valid;
    end else begin : g_next
      assign src_w[i]   = st_r[i-1];
      assign src_vld[i] = vld_r[i-1];
    end

    assign rdy[i] = !vld_r[i] || rdy[i+1];

    always_comb begin
      logic signed [qye_pkg::VEC_W-1:0] xs;
      logic signed [qye_pkg::VEC_W-1:0] ys;
      xs = src_w[i].x >>> i;
      ys = src_w[i].y >>> i;
      st_nxt[i].zero = src_w[i].zero;
      // Rotate towards the x axis, steering by the sign of y.
      if (!src_w[i].y[qye_pkg::VEC_W-1]) begin
        st_nxt[i].x = src_w[i].x + ys;
        st_nxt[i].y = src_w[i].y - xs;
        st_nxt[i].z = src_w[i].z + qye_pkg::ATAN_BAM[i];
      end else begin
        st_nxt[i].x = src_w[i].x - ys;
        st_nxt[i].y = src_w[i].y + xs;
        st_nxt[i].z = src_w[i].z - qye_pkg::ATAN_BAM[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) vld_r[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (src_vld[k] && rdy[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign out_vec   = st_r[STAGES-1];

endmodule

### sv/qye_scale.sv
// Angle wrap and scaling of binary angle units to radians and degrees.
module qye_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qye_pkg::vec_t in_vec,
  output logic          out_valid,
  input  logic          out_ready,
  output qye_pkg::yaw_t out_yaw
);

  logic signed [qye_pkg::RAD_PROD_W-1:0] rad_prod_r;
  logic signed [qye_pkg::DEG_PROD_W-1:0] deg_prod_r;
  logic                                  mul_vld_r;
  logic                                  mul_rdy;
  qye_pkg::yaw_t                         yaw_r;
  qye_pkg::yaw_t                         yaw_nxt;
  logic                                  yaw_vld_r;
  logic                                  yaw_rdy;

  logic signed [qye_pkg::ANG_W-1:0]      ang;
  logic signed [qye_pkg::RAD_PROD_W-1:0] rad_sum;
  logic signed [qye_pkg::DEG_PROD_W-1:0] deg_sum;

  assign yaw_rdy  = !yaw_vld_r || out_ready;
  assign mul_rdy  = !mul_vld_r || yaw_rdy;
  assign in_ready = mul_rdy;

  // The angle of minus pi is reported as plus pi; a zero vector gives zero.
  always_comb begin
    if (in_vec.zero) begin
      ang = '0;
    end else if (in_vec.z == qye_pkg::BAM_PI) begin
      ang = {1'b0, qye_pkg::BAM_PI};
    end else begin
      ang = {in_vec.z[qye_pkg::BAM_W-1], in_vec.z};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      yaw_vld_r <= 1'b0;
    end else begin
      if (mul_rdy) mul_vld_r <= in_valid;
      if (yaw_rdy) yaw_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && mul_rdy) begin
      rad_prod_r <= qye_pkg::RAD_PROD_W'(ang) * qye_pkg::RAD_PROD_W'(qye_pkg::PI_Q29);
      deg_prod_r <= qye_pkg::DEG_PROD_W'(ang) * qye_pkg::DEG_PROD_W'(qye_pkg::DEG_SCALE);
    end
    if (mul_vld_r && yaw_rdy) begin
      yaw_r <= yaw_nxt;
    end
  end

  always_comb begin
    rad_sum = (rad_prod_r + qye_pkg::RAD_ROUND) >>> qye_pkg::RAD_SHIFT;
    deg_sum = (deg_prod_r + qye_pkg::DEG_ROUND) >>> qye_pkg::DEG_SHIFT;
    yaw_nxt.rad = rad_sum[qye_pkg::OUT_W-1:0];
    yaw_nxt.deg = deg_sum[qye_pkg::OUT_W-1:0];
  end

  assign out_valid = yaw_vld_r;
  assign out_yaw   = yaw_r;

endmodule

### sv/quaternion_yaw_extract.sv
// Top level of the quaternion yaw extraction block.
// Takes one quaternion (x, y, z, w) in Q1.15 per item and returns its yaw as
// Q2.13 radians and Q8.7 degrees in (-pi, pi], with 0 for a zero vector. The
// block is a pipeline of 20 register stages: two in the front end (products,
// then numerator, denominator and pre-rotation), one per CORDIC iteration (16)
// and two in the scaler (constant multiply, then rounding). One item is
// accepted in every cycle while the output is not held; each stage holds its
// own valid bit and takes a new item whenever it is empty or its successor
// moves on, so a stalled output fills the bubbles behind it before
// in_tready falls.
`include "assert_macros.svh"

module quaternion_yaw_extract (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // yaw_radians, yaw_degrees
);

  localparam int CW = qye_pkg::COMPONENT_WIDTH;

  qye_pkg::quat_t quat;
  qye_pkg::vec_t  front_vec;
  qye_pkg::vec_t  cordic_vec;
  qye_pkg::yaw_t  yaw;
  logic           front_vld, front_rdy;
  logic           cordic_vld, cordic_rdy;
  logic           rad_in_range, deg_in_range, pipe_full;

  assign quat.x = in_tdata[CW-1:0];
  assign quat.y = in_tdata[2*CW-1:CW];
  assign quat.z = in_tdata[3*CW-1:2*CW];
  assign quat.w = in_tdata[4*CW-1:3*CW];

  qye_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_quat   (quat),
    .out_valid (front_vld),
    .out_ready (front_rdy),
    .out_vec   (front_vec)
  );

  qye_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_vld),
    .in_ready  (front_rdy),
    .in_vec    (front_vec),
    .out_valid (cordic_vld),
    .out_ready (cordic_rdy),
    .out_vec   (cordic_vec)
  );

  qye_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cordic_vld),
    .in_ready  (cordic_rdy),
    .in_vec    (cordic_vec),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_yaw   (yaw)
  );

  assign out_tdata = {yaw.deg, yaw.rad};

  assign rad_in_range = (yaw.rad >= -qye_pkg::YAW_RAD_MAX)
                     && (yaw.rad <= qye_pkg::YAW_RAD_MAX);
  assign deg_in_range = (yaw.deg >= -qye_pkg::YAW_DEG_MAX)
                     && (yaw.deg <= qye_pkg::YAW_DEG_MAX);
  assign pipe_full    = out_tvalid && !out_tready && cordic_vld && front_vld;

  `ASSERT_IMPLIES(a_rad_range, clk, rst_n, out_tvalid, rad_in_range, "yaw in radians out of range")
  `ASSERT_IMPLIES(a_deg_range, clk, rst_n, out_tvalid, deg_in_range, "yaw in degrees out of range")
  // The input only stalls once every stage holds an item and the output is held.
  `ASSERT_PROP(a_stall_full, clk, rst_n, in_tready || pipe_full, "input stalled with room left")

endmodule

### bench/quaternion_yaw_extract_test.sv
// Self-checking testbench for the quaternion yaw extraction block.
module quaternion_yaw_extract_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 430;
  localparam int LONG_HOLD = 300;
  localparam int STEPS = (qye_pkg::ITERATIONS < 24) ? qye_pkg::ITERATIONS : 24;
  localparam real TWO_PI = 6.283185307179586;

  // Arctangent of 2^-i, in units of 2^32 per turn.
  localparam longint ARCTAN_TURNS [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  class yaw_scoreboard;
    qye_pkg::yaw_t expected_yaw [$];
    int errors = 0;

    function qye_pkg::yaw_t compute_yaw(qye_pkg::quat_t q);
      longint qx, qy, qz, qw;
      longint num, den, vx, vy, ang, xs, ys, turn;
      qye_pkg::yaw_t r;
      qx = longint'(q.x);
      qy = longint'(q.y);
      qz = longint'(q.z);
      qw = longint'(q.w);
      num = 2 * (qw * qz + qx * qy);
      den = (longint'(1) <<< 30) - 2 * (qy * qy + qz * qz);
      r = '0;
      if (num == 0 && den == 0)
        return r;
      vx = den <<< 8;
      vy = num <<< 8;
      ang = 0;
      // A vector in the left half plane is turned through pi before the CORDIC.
      if (vx < 0) begin
        ang = (vy >= 0) ? (longint'(1) <<< 31) : -(longint'(1) <<< 31);
        vx = -vx;
        vy = -vy;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy >= 0) begin
          vx = vx + ys;
          vy = vy - xs;
          ang = ang + ARCTAN_TURNS[i];
        end else begin
          vx = vx - ys;
          vy = vy + xs;
          ang = ang - ARCTAN_TURNS[i];
        end
      end
      turn = longint'(int'(ang));
      // The range is half open at -pi, so -pi is reported as +pi.
      if (turn == -(longint'(1) <<< 31))
        turn = longint'(1) <<< 31;
      r.rad = 16'((turn * 1686629713 + (longint'(1) <<< 46)) >>> 47);
      r.deg = 16'((turn * 45 + (longint'(1) <<< 21)) >>> 22);
      return r;
    endfunction

    function void note_quat(qye_pkg::quat_t q);
      expected_yaw.push_back(compute_yaw(q));
    endfunction

    function void check_yaw(qye_pkg::yaw_t got);
      qye_pkg::yaw_t want;
      if (expected_yaw.size() == 0) begin
        $display("%0t: unexpected item rad=%0d deg=%0d", $time, got.rad, got.deg);
        errors++;
        return;
      end
      want = expected_yaw.pop_front();
      if (got.rad !== want.rad) begin
        $display("%0t: yaw_radians expected %0d actual %0d", $time, want.rad, got.rad);
        errors++;
      end
      if (got.deg !== want.deg) begin
        $display("%0t: yaw_degrees expected %0d actual %0d", $time, want.deg, got.deg);
        errors++;
      end
    endfunction

    function int pending();
      return expected_yaw.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  yaw_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int cycle_count = 0;

  quaternion_yaw_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off when asked for.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        board.check_yaw(qye_pkg::yaw_t'(out_tdata));
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic qye_pkg::quat_t make_quat(int x, int y, int z, int w);
    qye_pkg::quat_t q;
    q.x = 16'(x);
    q.y = 16'(y);
    q.z = 16'(z);
    q.w = 16'(w);
    return q;
  endfunction

  task automatic send_quat(qye_pkg::quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    do @(posedge clk); while (!in_tready);
    board.note_quat(q);
  endtask

  // Near-unit headings and raw noise in equal shares, with the degenerate families mixed in.
  function automatic qye_pkg::quat_t random_quat();
    int pick, x, y, z, w;
    real half;
    pick = $urandom_range(99);
    if (pick < 40) begin
      half = ($urandom_range(65535) / 65536.0) * TWO_PI;
      x = $urandom_range(4000) - 2000;
      y = $urandom_range(4000) - 2000;
      z = $rtoi(32000.0 * $sin(half));
      w = $rtoi(32000.0 * $cos(half));
    end else if (pick < 80) begin
      x = int'($signed(16'($urandom)));
      y = int'($signed(16'($urandom)));
      z = int'($signed(16'($urandom)));
      w = int'($signed(16'($urandom)));
    end else if (pick < 90) begin
      // Zero vector: y*y + z*z is a half and w*z cancels x*y.
      x = $urandom_range(65534) - 32767;
      y = $urandom_range(1) ? 16384 : -16384;
      z = $urandom_range(1) ? 16384 : -16384;
      w = (y == z) ? -x : x;
    end else begin
      // Numerator zero, denominator of either sign.
      x = $urandom_range(1) ? 0 : int'($signed(16'($urandom)));
      y = (x != 0) ? 0 : int'($signed(16'($urandom)));
      z = int'($signed(16'($urandom)));
      w = $urandom_range(1) ? 0 : $urandom_range(3) - 1;
      if (w != 0)
        z = 0;
    end
    return make_quat(x, y, z, w);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_quat(make_quat(0, 0, 0, 32767));
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(0, 16384, 16384, 0));
    send_quat(make_quat(1000, 16384, 16384, -1000));
    send_quat(make_quat(-32767, -16384, 16384, 32767));
    send_quat(make_quat(0, 0, 32767, 0));
    send_quat(make_quat(0, 0, 32767, -1));
    send_quat(make_quat(0, 0, 32767, 1));
    send_quat(make_quat(0, 0, 23170, 23170));
    send_quat(make_quat(0, 0, -23170, 23170));
    send_quat(make_quat(-32768, -32768, -32768, -32768));
    send_quat(make_quat(32767, 32767, 32767, 32767));
    send_quat(make_quat(-32768, 32767, -32768, 32767));
    send_quat(make_quat(32767, -32768, 32767, -32768));
    send_quat(make_quat(0, -32768, 0, 0));
    send_quat(make_quat(-32768, 0, 0, -32768));
    send_quat(make_quat(0, 0, -32768, -32768));
    send_quat(make_quat(0, 0, 1, 0));
    send_quat(make_quat(0, 1, 0, 1));
    send_quat(make_quat(12345, -6789, -321, 30000));

    send_idle_pct = 28;
    recv_idle_pct = 86;
    repeat (RANDOM_PER_PHASE) send_quat(random_quat());

    send_idle_pct = 86;
    recv_idle_pct = 28;
    repeat (RANDOM_PER_PHASE) send_quat(random_quat());

    // The output is held off while items keep coming, so the pipeline fills up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = LONG_HOLD;
    repeat (RANDOM_PER_PHASE) send_quat(random_quat());
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
